FILE: design/table_driven_dfa_runner_unit_defines.svh
// Assertion macros used by the checker file dtr_chk.sv.
`ifndef TABLE_DRIVEN_DFA_RUNNER_UNIT_DEFINES_SVH
`define TABLE_DRIVEN_DFA_RUNNER_UNIT_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define DTR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define DTR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/dtr_pkg.sv
package dtr_pkg;

  localparam int STATES   = 64;
  localparam int ALPHABET = 128;
  localparam int ST_W     = 6;
  localparam int SYM_W    = 7;
  localparam int ADDR_W   = ST_W + SYM_W;
  localparam int ENTRY_W  = ST_W + 1;
  localparam int ENTRIES  = STATES * ALPHABET;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_FILL   = 2'd1,
    REQ_ACCEPT = 2'd2,
    REQ_FEED   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_FEED
  } state_t;

  typedef struct packed {
    logic wr_entry;
    logic fill_load;
    logic fill_step;
    logic clr_step;
    logic acc_wr;
    logic feed_rd;
    logic feed_exec;
  } cmd_t;

  typedef struct packed {
    logic col_last;
    logic all_last;
  } sts_t;

endpackage

FILE: design/dtr_ctrl.sv
module dtr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_req_type,
  input  dtr_pkg::sts_t     sts,
  output dtr_pkg::cmd_t     cmd,
  output logic              busy
);

  dtr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtr_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      dtr_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.all_last) state_nxt = dtr_pkg::S_IDLE;
      end
      dtr_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (dtr_pkg::req_type_t'(in_req_type))
            dtr_pkg::REQ_WRITE:  cmd.wr_entry = 1'b1;
            dtr_pkg::REQ_FILL: begin
              cmd.fill_load = 1'b1;
              state_nxt     = dtr_pkg::S_FILL;
            end
            dtr_pkg::REQ_ACCEPT: cmd.acc_wr = 1'b1;
            dtr_pkg::REQ_FEED: begin
              cmd.feed_rd = 1'b1;
              state_nxt   = dtr_pkg::S_FEED;
            end
            default: state_nxt = dtr_pkg::S_IDLE;
          endcase
        end
      end
      dtr_pkg::S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.col_last) state_nxt = dtr_pkg::S_IDLE;
      end
      dtr_pkg::S_FEED: begin
        cmd.feed_exec = 1'b1;
        state_nxt     = dtr_pkg::S_IDLE;
      end
      default: state_nxt = dtr_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: design/dtr_dpath.sv
module dtr_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dtr_pkg::cmd_t                cmd,
  output dtr_pkg::sts_t                sts,
  input  logic [dtr_pkg::ST_W-1:0]     in_state_index,
  input  logic [dtr_pkg::SYM_W-1:0]    in_symbol,
  input  logic [dtr_pkg::ST_W-1:0]     in_next_state,
  input  logic                         in_next_valid,
  input  logic                         in_accept_value,
  input  logic                         in_last,
  output logic                         out_valid,
  output logic                         out_accepted
);

  // entry: {valid, destination}
  logic [dtr_pkg::ENTRY_W-1:0] tbl_mem [dtr_pkg::ENTRIES];

  logic [dtr_pkg::ADDR_W-1:0]  sweep_cnt_r;
  logic [dtr_pkg::ENTRY_W-1:0] fill_entry_r;
  logic [dtr_pkg::ENTRY_W-1:0] rdata_r;
  logic                        last_r;
  logic [dtr_pkg::ST_W-1:0]    cur_state_r;
  logic [dtr_pkg::STATES-1:0]  acc_bits_r;
  logic                        out_valid_r;
  logic                        out_accepted_r;

  logic                        mem_we;
  logic [dtr_pkg::ADDR_W-1:0]  mem_waddr;
  logic [dtr_pkg::ENTRY_W-1:0] mem_wdata;
  logic [dtr_pkg::ENTRY_W-1:0] in_entry;
  logic                        hit;
  logic [dtr_pkg::ST_W-1:0]    hit_state;

  assign in_entry = in_next_valid ? {1'b1, in_next_state} : '0;

  assign mem_we    = cmd.wr_entry | cmd.fill_step | cmd.clr_step;
  assign mem_waddr = cmd.wr_entry ? {in_state_index, in_symbol} : sweep_cnt_r;
  assign mem_wdata = cmd.wr_entry ? in_entry :
                     cmd.clr_step ? '0 : fill_entry_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.feed_rd) begin
      rdata_r <= tbl_mem[{cur_state_r, in_symbol}];
      last_r  <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_load) begin
      fill_entry_r <= in_entry;
    end
  end

  // shared sweep counter: full-table clear after reset, one row per fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
    end else if (cmd.fill_load) begin
      sweep_cnt_r <= {in_state_index, {dtr_pkg::SYM_W{1'b0}}};
    end else if (cmd.fill_step || cmd.clr_step) begin
      sweep_cnt_r <= sweep_cnt_r + dtr_pkg::ADDR_W'(1);
    end
  end

  assign sts.col_last = &sweep_cnt_r[dtr_pkg::SYM_W-1:0];
  assign sts.all_last = &sweep_cnt_r;

  assign hit       = rdata_r[dtr_pkg::ENTRY_W-1];
  assign hit_state = rdata_r[dtr_pkg::ST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_bits_r <= '0;
    end else if (cmd.acc_wr) begin
      acc_bits_r[in_state_index] <= in_accept_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_state_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.feed_exec & last_r;
      if (cmd.feed_exec) begin
        if (last_r) begin
          cur_state_r <= '0;
        end else if (hit) begin
          cur_state_r <= hit_state;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.feed_exec) begin
      out_accepted_r <= hit & acc_bits_r[hit_state];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = out_accepted_r;

endmodule

FILE: design/table_driven_dfa_runner_unit.sv
// DFA recognizer over a 64-state by 128-symbol transition table held in one
// single-port-write RAM. After reset the unit sweeps the whole table to "no
// transition", one entry per cycle; busy stays high and no request is taken.
// A request is taken when start is high and busy is low. Entry and
// accepting-bit writes leave busy low. A row fill writes one RAM entry per
// column after the request cycle, busy high meanwhile. A fed symbol holds
// busy high through the registered table read whose data becomes the next
// state. For a symbol marked last, out_valid is high for one cycle with
// out_accepted, registered after the table read; the result cannot be held
// off, so the receiver must take it in that cycle.
module table_driven_dfa_runner_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_req_type,
  input  logic [5:0] in_state_index,
  input  logic [6:0] in_symbol,
  input  logic [5:0] in_next_state,
  input  logic       in_next_valid,
  input  logic       in_accept_value,
  input  logic       in_last,
  output logic       out_valid,
  output logic       out_accepted
);

  dtr_pkg::cmd_t cmd;
  dtr_pkg::sts_t sts;

  dtr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  dtr_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_state_index  (in_state_index),
    .in_symbol       (in_symbol),
    .in_next_state   (in_next_state),
    .in_next_valid   (in_next_valid),
    .in_accept_value (in_accept_value),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_accepted    (out_accepted)
  );

endmodule

FILE: design/dtr_chk.sv
`include "table_driven_dfa_runner_unit_defines.svh"

module dtr_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_req_type,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_accepted
);

  logic req_take;
  logic lst_take;
  assign req_take = start && !busy;
  assign lst_take = req_take && in_req_type == dtr_pkg::REQ_FEED && in_last;

  `DTR_ASSERT_RST(a_clear_after_reset, !rst_n |=> busy && !out_valid, "no clear after reset")
  `DTR_ASSERT(a_result_has_request, out_valid |-> $past(lst_take, 2), "result without last")
  `DTR_ASSERT(a_fill_busy, req_take && in_req_type == dtr_pkg::REQ_FILL |=> busy, "fill not busy")
  `DTR_ASSERT(a_write_single, req_take && in_req_type == dtr_pkg::REQ_WRITE |=> !busy, "write stalls")
  `DTR_ASSERT(a_verdict_known, out_valid |-> !$isunknown(out_accepted), "out_accepted unknown")

endmodule

bind table_driven_dfa_runner_unit dtr_chk u_chk (.*);

FILE: bench/dfa_run_checker.sv
module dfa_run_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] in_req_type,
  input  logic [5:0] in_state_index,
  input  logic [6:0] in_symbol,
  input  logic [5:0] in_next_state,
  input  logic       in_next_valid,
  input  logic       in_accept_value,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_accepted,
  output int         errors,
  output int         pending,
  output int         checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // entry = {hit, dest}
  logic [dtr_pkg::ENTRY_W-1:0] trans_tbl [dtr_pkg::STATES][dtr_pkg::ALPHABET];
  logic                        accepting [dtr_pkg::STATES];
  logic [dtr_pkg::ST_W-1:0]    cur_state;
  bit                          verdict_q [$];
  bit                          want;
  int                          err_cnt;
  int                          n_chk;

  function automatic void dfa_step(dtr_pkg::req_type_t req, logic [dtr_pkg::ST_W-1:0] row,
                                   logic [dtr_pkg::SYM_W-1:0] sym,
                                   logic [dtr_pkg::ST_W-1:0] dst,
                                   logic vld, logic accv, logic lst);
    logic [dtr_pkg::ENTRY_W-1:0] ent;
    ent = {vld, vld ? dst : {dtr_pkg::ST_W{1'b0}}};
    case (req)
      dtr_pkg::REQ_WRITE: begin
        trans_tbl[row][sym] = ent;
      end
      dtr_pkg::REQ_FILL: begin
        for (int c = 0; c < dtr_pkg::ALPHABET; c++) trans_tbl[row][c] = ent;
      end
      dtr_pkg::REQ_ACCEPT: begin
        accepting[row] = accv;
      end
      dtr_pkg::REQ_FEED: begin
        ent = trans_tbl[cur_state][sym];
        if (ent[dtr_pkg::ST_W]) cur_state = ent[dtr_pkg::ST_W-1:0];
        if (lst) begin
          // missing final transition rejects
          verdict_q.push_back(ent[dtr_pkg::ST_W] & accepting[ent[dtr_pkg::ST_W-1:0]]);
          cur_state = '0;
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < dtr_pkg::STATES; r++) begin
        accepting[r] = 1'b0;
        for (int c = 0; c < dtr_pkg::ALPHABET; c++) trans_tbl[r][c] = '0;
      end
      cur_state = '0;
      verdict_q.delete();
    end else begin
      if (out_valid) begin
        if (verdict_q.size() == 0) begin
          $error("out_accepted: no result expected, got %0b", out_accepted);
          err_cnt++;
        end else begin
          want = verdict_q.pop_front();
          n_chk++;
          if (out_accepted !== want) begin
            $error("out_accepted: expected %0b, got %0b", want, out_accepted);
            err_cnt++;
          end
        end
      end
      if (start && !busy)
        dfa_step(dtr_pkg::req_type_t'(in_req_type), in_state_index, in_symbol,
                 in_next_state, in_next_valid, in_accept_value, in_last);
    end
    errors  <= err_cnt;
    pending <= verdict_q.size();
    checked <= n_chk;
  end

endmodule

FILE: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 50000;
  localparam int RAND_ITEMS  = 1400;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       start           = 1'b0;
  logic [1:0] in_req_type     = '0;
  logic [5:0] in_state_index  = '0;
  logic [6:0] in_symbol       = '0;
  logic [5:0] in_next_state   = '0;
  logic       in_next_valid   = 1'b0;
  logic       in_accept_value = 1'b0;
  logic       in_last         = 1'b0;
  logic       busy;
  logic       out_valid;
  logic       out_accepted;

  int errors;
  int pending;
  int checked;
  int req_cnt [4];
  int n_items;
  int quiet;
  bit idle_en = 1'b1;

  always #5 clk = ~clk;

  table_driven_dfa_runner_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_state_index  (in_state_index),
    .in_symbol       (in_symbol),
    .in_next_state   (in_next_state),
    .in_next_valid   (in_next_valid),
    .in_accept_value (in_accept_value),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_accepted    (out_accepted)
  );

  dfa_run_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_state_index  (in_state_index),
    .in_symbol       (in_symbol),
    .in_next_state   (in_next_state),
    .in_next_valid   (in_next_valid),
    .in_accept_value (in_accept_value),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_accepted    (out_accepted),
    .errors          (errors),
    .pending         (pending),
    .checked         (checked)
  );

  // watchdog: cycles with neither a request nor a result taken
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic issue(dtr_pkg::req_type_t req, logic [5:0] row, logic [6:0] sym,
                       logic [5:0] dst, logic vld, logic accv, logic lst);
    if (idle_en) begin
      while ($urandom_range(99) < 7) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start           <= 1'b1;
    in_req_type     <= req;
    in_state_index  <= row;
    in_symbol       <= sym;
    in_next_state   <= dst;
    in_next_valid   <= vld;
    in_accept_value <= accv;
    in_last         <= lst;
    do @(posedge clk); while (busy);
    req_cnt[int'(req)]++;
    n_items++;
  endtask

  task automatic wr_entry(logic [5:0] row, logic [6:0] sym, logic [5:0] dst, logic vld);
    issue(dtr_pkg::REQ_WRITE, row, sym, dst, vld, 1'($urandom_range(1)),
          1'($urandom_range(1)));
  endtask

  task automatic fill_row(logic [5:0] row, logic [5:0] dst, logic vld);
    issue(dtr_pkg::REQ_FILL, row, 7'($urandom_range(127)), dst, vld,
          1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic set_accept(logic [5:0] row, logic v);
    issue(dtr_pkg::REQ_ACCEPT, row, 7'($urandom_range(127)), 6'($urandom_range(63)),
          1'($urandom_range(1)), v, 1'($urandom_range(1)));
  endtask

  task automatic feed(logic [6:0] sym, logic lst);
    issue(dtr_pkg::REQ_FEED, 6'($urandom_range(63)), sym, 6'($urandom_range(63)),
          1'($urandom_range(1)), 1'($urandom_range(1)), lst);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  // small automaton over a few states and symbols, then strings through it
  task automatic run_episode();
    logic [5:0] sts [8];
    logic [6:0] syms [4];
    int n_str;
    int len;
    sts[0] = '0;
    for (int i = 1; i < 8; i++) sts[i] = 6'($urandom_range(63));
    for (int i = 0; i < 4; i++) syms[i] = 7'($urandom_range(127));
    for (int i = 0; i < 16; i++)
      wr_entry(sts[3'($urandom_range(7))], syms[2'($urandom_range(3))],
               sts[3'($urandom_range(7))], $urandom_range(9) != 0);
    for (int i = 0; i < 3; i++)
      set_accept(sts[3'($urandom_range(7))], 1'($urandom_range(1)));
    if ($urandom_range(3) == 0)
      fill_row(sts[3'($urandom_range(7))], sts[3'($urandom_range(7))],
               $urandom_range(4) != 0);
    n_str = $urandom_range(3, 7);
    for (int s = 0; s < n_str; s++) begin
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        // table updates in the middle of a string
        if ($urandom_range(19) == 0) begin
          if ($urandom_range(1))
            wr_entry(sts[3'($urandom_range(7))], syms[2'($urandom_range(3))],
                     sts[3'($urandom_range(7))], 1'($urandom_range(1)));
          else
            set_accept(sts[3'($urandom_range(7))], 1'($urandom_range(1)));
        end
        if ($urandom_range(9) != 0)
          feed(syms[2'($urandom_range(3))], k == len - 1);
        else
          feed(7'($urandom_range(127)), k == len - 1);
      end
    end
    if ($urandom_range(7) == 0)
      wr_entry(6'($urandom_range(63)), 7'($urandom_range(127)), 6'($urandom_range(63)),
               1'($urandom_range(1)));
  endtask

  initial begin
    int n_ep;
    int base;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: no transition rejects
    feed(7'd0, 1'b1);
    set_accept(6'd0, 1'b1);
    feed(7'd127, 1'b1);
    wr_entry(6'd0, 7'd127, 6'd63, 1'b1);
    set_accept(6'd63, 1'b1);
    feed(7'd127, 1'b1);
    // two-symbol string back to accepting state 0
    wr_entry(6'd63, 7'd0, 6'd0, 1'b1);
    feed(7'd127, 1'b0);
    feed(7'd0, 1'b1);
    fill_row(6'd63, 6'd63, 1'b1);
    feed(7'd127, 1'b0);
    feed(7'd85, 1'b1);
    // final lookup missing while sitting in an accepting state
    fill_row(6'd63, 6'd63, 1'b0);
    feed(7'd127, 1'b0);
    feed(7'd42, 1'b1);
    wr_entry(6'd0, 7'd127, 6'd63, 1'b0);
    feed(7'd127, 1'b1);
    // writes mid-string take effect at once
    wr_entry(6'd0, 7'd1, 6'd42, 1'b1);
    feed(7'd1, 1'b0);
    set_accept(6'd42, 1'b1);
    wr_entry(6'd42, 7'd2, 6'd42, 1'b1);
    feed(7'd2, 1'b1);
    set_accept(6'd42, 1'b0);
    set_accept(6'd0, 1'b0);
    drain();

    base = n_items;
    n_ep = 0;
    while (n_items < base + RAND_ITEMS) begin
      idle_en = !(n_items >= base + 500 && n_items < base + 800);
      run_episode();
      n_ep++;
      if (n_ep == 9) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("tb: %0d requests: %0d entry writes, %0d row fills, %0d accept writes,",
             n_items, req_cnt[dtr_pkg::REQ_WRITE], req_cnt[dtr_pkg::REQ_FILL],
             req_cnt[dtr_pkg::REQ_ACCEPT]);
    $display("tb: %0d symbols, %0d string verdicts compared over %0d episodes, %0d errors",
             req_cnt[dtr_pkg::REQ_FEED], checked, n_ep, errors);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/dtr_pkg.sv
design/dtr_ctrl.sv
design/dtr_dpath.sv
design/table_driven_dfa_runner_unit.sv
design/dtr_chk.sv
bench/dfa_run_checker.sv
bench/tb.sv
